// ----- rtl/clex_pkg.sv -----
// Package for the C subset lexer: token and group types, codes, keyword table
// and the character class and token closing functions.
// No dependencies; every other file of the block but clex_if.sv imports it.
`default_nettype none

package clex_pkg;

    localparam logic [15:0] MAX_INPUT = 16'hFFFF;
    localparam logic [34:0] NUM_MAX   = 35'd2147483647;
    localparam int          QDEPTH    = 4;
    localparam int          QAW       = $clog2(QDEPTH);

    // Lexer modes.
    localparam logic [2:0] M_IDLE  = 3'd0;
    localparam logic [2:0] M_NUM   = 3'd1;
    localparam logic [2:0] M_IDENT = 3'd2;
    localparam logic [2:0] M_PUNCT = 3'd3;
    localparam logic [2:0] M_DROP  = 3'd4;

    // Token kinds.
    localparam logic [2:0] K_NUM   = 3'd0;
    localparam logic [2:0] K_IDENT = 3'd1;
    localparam logic [2:0] K_KWORD = 3'd2;
    localparam logic [2:0] K_PUNCT = 3'd3;
    localparam logic [2:0] K_END   = 3'd4;
    localparam logic [2:0] K_ERROR = 3'd5;

    // Error codes.
    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_LARGE  = 3'd1;
    localparam logic [2:0] ERR_LETTER = 3'd2;
    localparam logic [2:0] ERR_UPPER  = 3'd3;
    localparam logic [2:0] ERR_LONG   = 3'd4;
    localparam logic [2:0] ERR_BYTE   = 3'd5;

    localparam logic [7:0] CH_EQ = 8'h3D;

    localparam logic [7:0] KW_TEXT [5][6] = '{
        '{"r", "e", "t", "u", "r", "n"},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00}
    };
    localparam logic [15:0] KW_LEN [5] = '{16'd6, 16'd2, 16'd4, 16'd3, 16'd5};

    typedef struct packed {
        logic [2:0]  kind;
        logic [30:0] value;
        logic [7:0]  second_byte;
        logic [15:0] start_offset;
        logic [15:0] token_length;
        logic [2:0]  error_code;
        logic        last_result;
    } t_tok;

    // All tokens caused by one source byte (one to three).
    typedef struct packed {
        logic [1:0]     cnt;
        t_tok [2:0]     tok;
    } t_grp;

    typedef struct packed {
        logic       emit;
        t_tok       tok;
        logic [2:0] err;
    } t_fin;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return c >= "a" && c <= "z";
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return c >= "A" && c <= "Z";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    function automatic t_tok mk_tok(input logic [2:0] kind, input logic [30:0] value,
                                    input logic [7:0] second, input logic [15:0] start,
                                    input logic [15:0] len, input logic [2:0] err,
                                    input logic lastr);
        t_tok t;
        t.kind         = kind;
        t.value        = value;
        t.second_byte  = second;
        t.start_offset = start;
        t.token_length = len;
        t.error_code   = err;
        t.last_result  = lastr;
        return t;
    endfunction

    // Closes the open token: gives the token to emit, or an error code.
    function automatic t_fin f_finish(input logic [2:0] mode, input logic [30:0] acc,
                                      input logic ovf, input logic [5:0][7:0] ident,
                                      input logic [7:0] pend, input logic [15:0] tstart,
                                      input logic [15:0] tcount);
        t_fin f;
        logic match;
        logic found;
        logic [30:0] kidx;
        f.emit = 1'b0;
        f.err  = ERR_NONE;
        f.tok  = '0;
        found  = 1'b0;
        kidx   = '0;
        if (mode == M_NUM) begin
            if (ovf) begin
                f.err = ERR_LARGE;
            end else begin
                f.emit = 1'b1;
                f.tok  = mk_tok(K_NUM, acc, 8'h00, tstart, tcount, ERR_NONE, 1'b0);
            end
        end else if (mode == M_IDENT) begin
            for (int k = 0; k < 5; k++) begin
                match = (tcount == KW_LEN[k]);
                for (int j = 0; j < 6; j++) begin
                    if (16'(j) < KW_LEN[k] && ident[j] != KW_TEXT[k][j]) begin
                        match = 1'b0;
                    end
                end
                if (match) begin
                    found = 1'b1;
                    kidx  = 31'(k);
                end
            end
            if (found) begin
                f.emit = 1'b1;
                f.tok  = mk_tok(K_KWORD, kidx, 8'h00, tstart, tcount, ERR_NONE, 1'b0);
            end else if (tcount != 16'd1) begin
                f.err = ERR_LONG;
            end else begin
                f.emit = 1'b1;
                f.tok  = mk_tok(K_IDENT, {23'd0, ident[0]}, 8'h00, tstart, 16'd1,
                                ERR_NONE, 1'b0);
            end
        end else if (mode == M_PUNCT) begin
            f.emit = 1'b1;
            f.tok  = mk_tok(K_PUNCT, {23'd0, pend}, 8'h00, tstart, 16'd1, ERR_NONE, 1'b0);
        end
        return f;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/clex_if.sv -----
// Channel interfaces of the C subset lexer: source bytes in, tokens out.
// Depends on nothing but the valid/ready handshake convention.
`default_nettype none

interface clex_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       last;
    modport source(output valid, char_byte, last, input ready);
    modport sink(input valid, char_byte, last, output ready);
endinterface

interface clex_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [30:0] value;
    logic [7:0]  second_byte;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [2:0]  error_code;
    logic        last_result;
    modport source(output valid, kind, value, second_byte, start_offset, token_length,
                   error_code, last_result, input ready);
    modport sink(input valid, kind, value, second_byte, start_offset, token_length,
                 error_code, last_result, output ready);
endinterface

`default_nettype wire

// ----- rtl/clex_front.sv -----
// Front end of the lexer: takes one byte a cycle while not full, advances the
// lexer state and builds the token group the byte completes. Uses clex_pkg, clex_in_if.
`default_nettype none

module clex_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    clex_in_if.sink           i_in,
    input  wire logic         i_full,
    output logic              o_push,
    output clex_pkg::t_grp    o_grp
);
    import clex_pkg::*;

    logic [2:0]       r_mode,   n_mode;
    logic [30:0]      r_acc,    n_acc;
    logic             r_ovf,    n_ovf;
    logic [5:0][7:0]  r_ident,  n_ident;
    logic [7:0]       r_pend,   n_pend;
    logic [15:0]      r_tstart, n_tstart;
    logic [15:0]      r_tcount, n_tcount;
    logic [15:0]      r_bpos,   n_bpos;

    logic        accept;
    logic [7:0]  c;
    logic        lst;
    logic [2:0]  err;
    logic [15:0] err_at;
    logic        used;
    logic        rst_all;
    logic [34:0] acc10;
    t_fin        fin;
    t_grp        grp;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign c          = i_in.char_byte;
    assign lst        = i_in.last;

    // Multiply by ten as two shifted adds, then the new digit.
    assign acc10 = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {31'd0, c[3:0]};

    always_comb begin
        n_mode   = r_mode;
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        n_ident  = r_ident;
        n_pend   = r_pend;
        n_tstart = r_tstart;
        n_tcount = r_tcount;
        n_bpos   = r_bpos;
        err      = ERR_NONE;
        err_at   = 16'd0;
        used     = 1'b0;
        rst_all  = 1'b0;
        fin      = '0;
        grp      = '0;

        if (r_mode == M_DROP) begin
            if (lst) begin
                rst_all = 1'b1;
            end else if (r_bpos < MAX_INPUT) begin
                n_bpos = r_bpos + 16'd1;
            end
        end else begin
            // Continue or close the open token.
            unique case (r_mode)
                M_NUM: begin
                    if (is_digit(c)) begin
                        if (acc10 > NUM_MAX) begin
                            n_acc = NUM_MAX[30:0];
                            n_ovf = 1'b1;
                        end else begin
                            n_acc = acc10[30:0];
                        end
                        if (r_tcount != 16'hFFFF) n_tcount = r_tcount + 16'd1;
                        used = 1'b1;
                    end else if (r_ovf) begin
                        err    = ERR_LARGE;
                        err_at = r_tstart;
                    end else if (is_lower(c) || is_upper(c) || c == ".") begin
                        err    = ERR_LETTER;
                        err_at = r_tstart;
                    end else begin
                        fin    = f_finish(r_mode, r_acc, r_ovf, r_ident, r_pend,
                                          r_tstart, r_tcount);
                        n_mode = M_IDLE;
                        if (fin.emit) begin
                            grp.tok[grp.cnt] = fin.tok;
                            grp.cnt          = grp.cnt + 2'd1;
                        end
                    end
                end
                M_IDENT: begin
                    if (is_lower(c) || is_upper(c) || is_digit(c) || c == "_") begin
                        if (r_tcount < 16'd6) n_ident[r_tcount[2:0]] = c;
                        if (r_tcount != 16'hFFFF) n_tcount = r_tcount + 16'd1;
                        used = 1'b1;
                    end else begin
                        fin    = f_finish(r_mode, r_acc, r_ovf, r_ident, r_pend,
                                          r_tstart, r_tcount);
                        n_mode = M_IDLE;
                        err    = fin.err;
                        err_at = r_tstart;
                        if (fin.emit) begin
                            grp.tok[grp.cnt] = fin.tok;
                            grp.cnt          = grp.cnt + 2'd1;
                        end
                    end
                end
                M_PUNCT: begin
                    n_mode = M_IDLE;
                    if (c == CH_EQ) begin
                        grp.tok[grp.cnt] = mk_tok(K_PUNCT, {23'd0, r_pend}, CH_EQ,
                                                  r_tstart, 16'd2, ERR_NONE, 1'b0);
                        grp.cnt          = grp.cnt + 2'd1;
                        used             = 1'b1;
                    end else begin
                        grp.tok[grp.cnt] = mk_tok(K_PUNCT, {23'd0, r_pend}, 8'h00,
                                                  r_tstart, 16'd1, ERR_NONE, 1'b0);
                        grp.cnt          = grp.cnt + 2'd1;
                    end
                end
                default: begin
                end
            endcase

            // A byte not taken by the open token starts something new.
            if (err == ERR_NONE && !used) begin
                priority if (is_space(c)) begin
                end else if (is_digit(c)) begin
                    n_mode   = M_NUM;
                    n_acc    = {27'd0, c[3:0]};
                    n_ovf    = 1'b0;
                    n_tstart = r_bpos;
                    n_tcount = 16'd1;
                end else if (is_lower(c)) begin
                    n_mode       = M_IDENT;
                    n_ident[0]   = c;
                    n_tstart     = r_bpos;
                    n_tcount     = 16'd1;
                end else if (is_upper(c)) begin
                    err    = ERR_UPPER;
                    err_at = r_bpos;
                end else if (c == CH_EQ || c == "!" || c == "<" || c == ">") begin
                    n_mode   = M_PUNCT;
                    n_pend   = c;
                    n_tstart = r_bpos;
                    n_tcount = 16'd1;
                end else if (is_punct(c)) begin
                    grp.tok[grp.cnt] = mk_tok(K_PUNCT, {23'd0, c}, 8'h00, r_bpos, 16'd1,
                                              ERR_NONE, 1'b0);
                    grp.cnt          = grp.cnt + 2'd1;
                end else begin
                    err    = ERR_BYTE;
                    err_at = r_bpos;
                end
            end

            // The final byte flushes the open token and closes the text.
            if (err == ERR_NONE && lst) begin
                fin    = f_finish(n_mode, n_acc, n_ovf, n_ident, n_pend, n_tstart,
                                  n_tcount);
                err    = fin.err;
                err_at = n_tstart;
                if (fin.emit) begin
                    grp.tok[grp.cnt] = fin.tok;
                    grp.cnt          = grp.cnt + 2'd1;
                end
                if (fin.err == ERR_NONE) begin
                    grp.tok[grp.cnt] = mk_tok(K_END, 31'd0, 8'h00,
                                              (r_bpos < MAX_INPUT) ? r_bpos + 16'd1 : r_bpos,
                                              16'd0, ERR_NONE, 1'b1);
                    grp.cnt          = grp.cnt + 2'd1;
                    rst_all          = 1'b1;
                end
            end

            if (err != ERR_NONE) begin
                grp.tok[grp.cnt] = mk_tok(K_ERROR, 31'd0, 8'h00, err_at, 16'd0, err, 1'b1);
                grp.cnt          = grp.cnt + 2'd1;
                if (lst) begin
                    rst_all = 1'b1;
                end else begin
                    n_mode = M_DROP;
                end
            end

            if (!rst_all && r_bpos < MAX_INPUT) begin
                n_bpos = r_bpos + 16'd1;
            end
        end

        if (rst_all) begin
            n_mode   = M_IDLE;
            n_acc    = 31'd0;
            n_ovf    = 1'b0;
            n_pend   = 8'h00;
            n_tstart = 16'd0;
            n_tcount = 16'd0;
            n_bpos   = 16'd0;
        end
    end

    assign o_push = accept && grp.cnt != 2'd0;
    assign o_grp  = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_acc    <= 31'd0;
            r_ovf    <= 1'b0;
            r_pend   <= 8'h00;
            r_tstart <= 16'd0;
            r_tcount <= 16'd0;
            r_bpos   <= 16'd0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_acc    <= n_acc;
            r_ovf    <= n_ovf;
            r_pend   <= n_pend;
            r_tstart <= n_tstart;
            r_tcount <= n_tcount;
            r_bpos   <= n_bpos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ident <= n_ident;
        end
    end

    // While bytes are being dropped after an error, nothing is emitted.
    a_drop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_mode == M_DROP) |-> !o_push)
        else $error("token emitted while dropping bytes");

    // An error that is not on the final byte leaves the lexer dropping bytes.
    a_err_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && err != ERR_NONE && !lst) |=> r_mode == M_DROP)
        else $error("lexer not dropping after an error");

endmodule

`default_nettype wire

// ----- rtl/clex_queue.sv -----
// Short queue of token groups between the lexer front and the output back end.
// Uses clex_pkg for the group type and depth.
`default_nettype none

module clex_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire clex_pkg::t_grp  i_data,
    output logic                 o_full,
    output logic                 o_valid,
    output clex_pkg::t_grp       o_data,
    input  wire logic            i_pop
);
    import clex_pkg::*;

    t_grp               r_mem [QDEPTH];
    logic [QAW-1:0]     r_wp;
    logic [QAW-1:0]     r_rp;
    logic [QAW:0]       r_cnt;

    assign o_full  = r_cnt == (QAW+1)'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("write into a full queue");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("read from an empty queue");

endmodule

`default_nettype wire

// ----- rtl/clex_back.sv -----
// Back end of the lexer: walks the head group of the queue and hands its tokens
// out one per cycle while the sink is ready, through an output register. Uses clex_pkg, clex_out_if.
`default_nettype none

module clex_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire clex_pkg::t_grp  i_head,
    output logic                 o_pop,
    clex_out_if.source           o_out
);
    import clex_pkg::*;

    t_tok        r_tok;
    logic        r_valid;
    logic [1:0]  r_idx;
    logic        load;
    logic        last_in_grp;

    assign load        = i_q_valid && (!r_valid || o_out.ready);
    assign last_in_grp = r_idx == i_head.cnt - 2'd1;
    assign o_pop       = load && last_in_grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last_in_grp ? 2'd0 : r_idx + 2'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok <= i_head.tok[r_idx];
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.kind         = r_tok.kind;
    assign o_out.value        = r_tok.value;
    assign o_out.second_byte  = r_tok.second_byte;
    assign o_out.start_offset = r_tok.start_offset;
    assign o_out.token_length = r_tok.token_length;
    assign o_out.error_code   = r_tok.error_code;
    assign o_out.last_result  = r_tok.last_result;

    // The walk position never passes the size of the group being read.
    a_idx_in_grp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> (r_idx < i_head.cnt))
        else $error("token index beyond its group");

endmodule

`default_nettype wire

// ----- rtl/c_subset_lexer.sv -----
// C subset lexer: one source byte in per cycle while the queue has room, tokens
// out one per cycle while the output is ready. The front end classifies each
// byte and accepts a new one every cycle while its four-entry group queue has
// room; a byte completes up to three tokens (a closed token, a one-byte
// punctuator and the end token), which the back end hands out one per cycle. A
// completed token is written into the group queue and then into the output
// register. Uses clex_pkg and clex_if.
`default_nettype none

module c_subset_lexer (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    clex_in_if.sink      i_in,
    clex_out_if.source   o_out
);
    import clex_pkg::*;

    logic  push;
    logic  pop;
    logic  full;
    logic  q_valid;
    t_grp  grp_in;
    t_grp  grp_head;

    clex_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_grp   (grp_in)
    );

    clex_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (grp_in),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (grp_head),
        .i_pop   (pop)
    );

    clex_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (grp_head),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
